/* design/rcp_pkg.sv */
// Package: constants, codes and the pipeline word type of the column projection block
`default_nettype none
package rcp_pkg;

    localparam int SCREEN_ROWS = 1024;
    localparam int HALF_ROWS   = SCREEN_ROWS / 2;
    localparam int HEIGHT_CAP  = 10 * SCREEN_ROWS;
    localparam int HEIGHT_W    = $clog2(HEIGHT_CAP + 1);
    localparam int ROW_W       = $clog2(SCREEN_ROWS) + 1;

    // height dividend is SCREEN_ROWS in Q16.16
    localparam int HNUM_W = $clog2(SCREEN_ROWS) + 17;
    localparam logic [HNUM_W-1:0] HNUM = HNUM_W'(SCREEN_ROWS) << 16;

    localparam int WDIV_N  = 41;
    localparam int PROD_W  = 57;

    // stage map
    localparam int ST_SAT   = 1;
    localparam int ST_WDIV0 = 2;
    localparam int ST_WFIN  = ST_WDIV0 + WDIV_N;
    localparam int ST_HDIV0 = ST_WFIN + 1;
    localparam int ST_FIN   = ST_HDIV0 + HNUM_W;
    localparam int STAGES   = ST_FIN + 1;

    // wall distance modes
    localparam logic [1:0] WMODE_DIV  = 2'd0;
    localparam logic [1:0] WMODE_ZERO = 2'd1;
    localparam logic [1:0] WMODE_MAX  = 2'd2;

    localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                sign_x;
        logic                sign_y;
        logic [PROD_W-1:0]   prod_x;
        logic [PROD_W-1:0]   prod_y;
        logic [31:0]         fd_x;
        logic [31:0]         fd_y;
        logic [1:0]          wmode;
        logic [WDIV_N-1:0]   wnum;
        logic [17:0]         wden;
        logic [17:0]         wrem;
        logic [WDIV_N-1:0]   wquo;
        logic [31:0]         wd;
        logic                hzero;
        logic [31:0]         hrem;
        logic [HNUM_W-1:0]   hquo;
        logic [13:0]         height;
        logic [9:0]          top;
        logic [9:0]          bot;
    } item_t;

endpackage
`default_nettype wire

/* design/raycast_column_projection.sv */
// Top level: pipelined raycaster column projection (step signs, side distances, wall slice)
//
// One word per screen column enters on in_valid/in_stall and one result word
// leaves on out_valid/out_stall. The datapath is a straight pipeline of
// rcp_pkg::STAGES register stages (72 with 1024 rows): a multiply stage, a
// saturation stage, a 41-stage restoring divider for the wall distance (one
// quotient bit per stage), a wrap-up stage, a restoring divider for the line
// height (one bit per stage, 27 stages at 1024 rows) and a final row stage.
// Throughput is one word per cycle while the receiver does not stall.
// Valid bits travel with the data. When the receiver stalls while the last
// stage holds a word, the whole pipeline freezes and in_stall rises, so
// nothing is dropped or repeated; bubbles are carried along.
// Reset clears all valid bits; payload registers are not reset.
// The block holds no state between words.
`default_nettype none
module raycast_column_projection (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [23:0]         player_pos_x,
    input  wire logic [23:0]         player_pos_y,
    input  wire logic signed [17:0]  dir_x,
    input  wire logic signed [17:0]  dir_y,
    input  wire logic [31:0]         delta_x,
    input  wire logic [31:0]         delta_y,
    input  wire logic [7:0]          start_cell_x,
    input  wire logic [7:0]          start_cell_y,
    input  wire logic [7:0]          hit_cell_x,
    input  wire logic [7:0]          hit_cell_y,
    input  wire logic                hit_side,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     step_sign_x,
    output logic                     step_sign_y,
    output logic [31:0]              first_dist_x,
    output logic [31:0]              first_dist_y,
    output logic [31:0]              wall_dist,
    output logic [13:0]              column_height,
    output logic [9:0]               top_row,
    output logic [9:0]               bottom_row
);

    localparam int L = rcp_pkg::STAGES;

    rcp_pkg::item_t pipe_reg  [0:L-1];
    rcp_pkg::item_t pipe_next [0:L-1];
    logic [L-1:0]   vld_reg;
    logic           advance;

    // freeze everything when the last word cannot leave
    assign advance  = !vld_reg[L-1] || !out_stall;
    assign in_stall = !advance;

    genvar k;
    generate
        for (k = 0; k < L; k++) begin : g_stage
            if (k == 0) begin : g_entry
                // form offsets and products, prepare the wall divider
                always_comb
                begin
                    rcp_pkg::item_t  it;
                    logic signed [26:0] off_x;
                    logic signed [26:0] off_y;
                    logic [24:0]        op_x;
                    logic [24:0]        op_y;
                    logic [7:0]         hc;
                    logic [23:0]        p;
                    logic signed [17:0] dsel;
                    logic               neg;
                    logic signed [26:0] num;
                    logic [26:0]        nmag;
                    it = '0;
                    it.sign_x = dir_x[17];
                    it.sign_y = dir_y[17];
                    off_x = dir_x[17]
                        ? ($signed({3'b0, player_pos_x}) - $signed({3'b0, start_cell_x, 16'b0}))
                        : ($signed({3'b0, start_cell_x, 16'b0}) + 27'sd65536
                           - $signed({3'b0, player_pos_x}));
                    off_y = dir_y[17]
                        ? ($signed({3'b0, player_pos_y}) - $signed({3'b0, start_cell_y, 16'b0}))
                        : ($signed({3'b0, start_cell_y, 16'b0}) + 27'sd65536
                           - $signed({3'b0, player_pos_y}));
                    op_x = (off_x > 27'sd0) ? off_x[24:0] : 25'd0;
                    op_y = (off_y > 27'sd0) ? off_y[24:0] : 25'd0;
                    it.prod_x = rcp_pkg::PROD_W'(op_x) * rcp_pkg::PROD_W'(delta_x);
                    it.prod_y = rcp_pkg::PROD_W'(op_y) * rcp_pkg::PROD_W'(delta_y);

                    hc   = hit_side ? hit_cell_y : hit_cell_x;
                    p    = hit_side ? player_pos_y : player_pos_x;
                    dsel = hit_side ? dir_y : dir_x;
                    neg  = dsel[17];
                    num  = $signed({3'b0, hc, 16'b0}) - $signed({3'b0, p})
                           + (neg ? 27'sd65536 : 27'sd0);
                    nmag = num[26] ? 27'(-num) : 27'(num);
                    if (dsel == 18'sd0)
                        it.wmode = rcp_pkg::WMODE_MAX;
                    else if (num == 27'sd0 || (num[26] != neg))
                        it.wmode = rcp_pkg::WMODE_ZERO;
                    else
                        it.wmode = rcp_pkg::WMODE_DIV;
                    it.wnum = {nmag[24:0], 16'b0};
                    it.wden = neg ? 18'(~dsel + 18'sd1) : 18'(dsel);
                    it.wrem = '0;
                    it.wquo = '0;
                    pipe_next[k] = it;
                end
            end else if (k == rcp_pkg::ST_SAT) begin : g_sat
                // saturate first side distances
                always_comb
                begin
                    rcp_pkg::item_t it;
                    it = pipe_reg[k-1];
                    it.fd_x = (it.prod_x[56:48] != 9'd0) ? rcp_pkg::DIST_MAX
                                                         : it.prod_x[47:16];
                    it.fd_y = (it.prod_y[56:48] != 9'd0) ? rcp_pkg::DIST_MAX
                                                         : it.prod_y[47:16];
                    pipe_next[k] = it;
                end
            end else if (k < rcp_pkg::ST_WFIN) begin : g_wdiv
                localparam int J = rcp_pkg::WDIV_N - 1 - (k - rcp_pkg::ST_WDIV0);
                // one restoring step of the wall divider
                always_comb
                begin
                    rcp_pkg::item_t it;
                    logic [18:0]    trial;
                    it = pipe_reg[k-1];
                    trial = {it.wrem, it.wnum[J]};
                    if (trial >= {1'b0, it.wden})
                    begin
                        trial      = trial - {1'b0, it.wden};
                        it.wquo[J] = 1'b1;
                    end
                    it.wrem = trial[17:0];
                    pipe_next[k] = it;
                end
            end else if (k == rcp_pkg::ST_WFIN) begin : g_wfin
                // resolve wall distance, prepare height divider
                always_comb
                begin
                    rcp_pkg::item_t it;
                    it = pipe_reg[k-1];
                    unique case (it.wmode)
                        rcp_pkg::WMODE_MAX:  it.wd = rcp_pkg::DIST_MAX;
                        rcp_pkg::WMODE_ZERO: it.wd = 32'd0;
                        default:
                            it.wd = (it.wquo[40:32] != 9'd0) ? rcp_pkg::DIST_MAX
                                                             : it.wquo[31:0];
                    endcase
                    it.hzero = (it.wd == 32'd0);
                    it.hrem  = '0;
                    it.hquo  = '0;
                    pipe_next[k] = it;
                end
            end else if (k < rcp_pkg::ST_FIN) begin : g_hdiv
                localparam int J = rcp_pkg::HNUM_W - 1 - (k - rcp_pkg::ST_HDIV0);
                // one restoring step of the height divider
                always_comb
                begin
                    rcp_pkg::item_t it;
                    logic [32:0]    trial;
                    it = pipe_reg[k-1];
                    trial = {it.hrem, rcp_pkg::HNUM[J]};
                    if (trial >= {1'b0, it.wd})
                    begin
                        trial      = trial - {1'b0, it.wd};
                        it.hquo[J] = 1'b1;
                    end
                    it.hrem = trial[31:0];
                    pipe_next[k] = it;
                end
            end else begin : g_fin
                // cap height, place the slice rows
                always_comb
                begin
                    rcp_pkg::item_t  it;
                    logic [rcp_pkg::HEIGHT_W-1:0] h;
                    logic [rcp_pkg::HEIGHT_W-1:0] h2;
                    logic [rcp_pkg::HEIGHT_W:0]   bsum;
                    it = pipe_reg[k-1];
                    if (it.hzero || it.hquo > rcp_pkg::HNUM_W'(rcp_pkg::HEIGHT_CAP))
                        h = rcp_pkg::HEIGHT_W'(rcp_pkg::HEIGHT_CAP);
                    else
                        h = rcp_pkg::HEIGHT_W'(it.hquo);
                    h2 = h >> 1;
                    if (h2 >= rcp_pkg::HEIGHT_W'(rcp_pkg::HALF_ROWS))
                        it.top = 10'd0;
                    else
                        it.top = 10'(rcp_pkg::HEIGHT_W'(rcp_pkg::HALF_ROWS) - h2);
                    bsum = (rcp_pkg::HEIGHT_W + 1)'(rcp_pkg::HALF_ROWS)
                           + (rcp_pkg::HEIGHT_W + 1)'(h2);
                    if (bsum >= (rcp_pkg::HEIGHT_W + 1)'(rcp_pkg::SCREEN_ROWS))
                        it.bot = 10'(rcp_pkg::SCREEN_ROWS - 1);
                    else
                        it.bot = 10'(bsum);
                    it.height = 14'(h);
                    pipe_next[k] = it;
                end
            end

            // advance payload
            always_ff @(posedge clk)
            begin
                if (advance)
                    pipe_reg[k] <= pipe_next[k];
            end
        end
    endgenerate

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[L-2:0], in_valid};
    end

    assign out_valid     = vld_reg[L-1];
    assign step_sign_x   = pipe_reg[L-1].sign_x;
    assign step_sign_y   = pipe_reg[L-1].sign_y;
    assign first_dist_x  = pipe_reg[L-1].fd_x;
    assign first_dist_y  = pipe_reg[L-1].fd_y;
    assign wall_dist     = pipe_reg[L-1].wd;
    assign column_height = pipe_reg[L-1].height;
    assign top_row       = pipe_reg[L-1].top;
    assign bottom_row    = pipe_reg[L-1].bot;

endmodule
`default_nettype wire

/* design/rcp_checker.sv */
// Checker: port-level assertions for the column projection block, bound to the top level
`default_nettype none
module rcp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] wall_dist,
    input wire logic [13:0] column_height,
    input wire logic [9:0]  top_row,
    input wire logic [9:0]  bottom_row
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(wall_dist))
        else $error("stalled result word changed");

    // back-pressure reaches the input
    a_stall_prop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input accepted while output stalled");

    // slice rows are ordered
    a_rows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> top_row <= bottom_row)
        else $error("top row below bottom row");

    // zero distance gives capped height, maximum distance gives none
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && wall_dist == 32'd0 |-> column_height == 14'(rcp_pkg::HEIGHT_CAP))
        else $error("zero distance not capped");

    a_far: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && wall_dist == rcp_pkg::DIST_MAX |-> column_height == 14'd0)
        else $error("maximum distance gave nonzero height");

endmodule

bind raycast_column_projection rcp_checker u_rcp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .wall_dist     (wall_dist),
    .column_height (column_height),
    .top_row       (top_row),
    .bottom_row    (bottom_row)
);
`default_nettype wire

/* tb/sv/raycast_column_projection_test.sv */
// Testbench: directed table with fixed or predicted results and random words vs a predictor
`timescale 1ns / 100ps
`default_nettype none
module raycast_column_projection_test;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int RANDOM_WORDS    = 2000;
    localparam int CALM_WORDS      = 300;

    typedef struct packed {
        logic [23:0]        pos_x;
        logic [23:0]        pos_y;
        logic signed [17:0] ray_x;
        logic signed [17:0] ray_y;
        logic [31:0]        step_len_x;
        logic [31:0]        step_len_y;
        logic [7:0]         cell_x;
        logic [7:0]         cell_y;
        logic [7:0]         wall_cell_x;
        logic [7:0]         wall_cell_y;
        logic               wall_side;
    } column_t;

    typedef struct packed {
        logic        neg_x;
        logic        neg_y;
        logic [31:0] side_x;
        logic [31:0] side_y;
        logic [31:0] perp;
        logic [13:0] height;
        logic [9:0]  top;
        logic [9:0]  bot;
    } slice_t;

    typedef struct {
        column_t col;
        logic    typed;
        slice_t  want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [23:0] player_pos_x;
    logic [23:0] player_pos_y;
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;
    logic [31:0] delta_x;
    logic [31:0] delta_y;
    logic [7:0]  start_cell_x;
    logic [7:0]  start_cell_y;
    logic [7:0]  hit_cell_x;
    logic [7:0]  hit_cell_y;
    logic        hit_side;
    logic        out_valid;
    logic        out_stall;
    logic        step_sign_x;
    logic        step_sign_y;
    logic [31:0] first_dist_x;
    logic [31:0] first_dist_y;
    logic [31:0] wall_dist;
    logic [13:0] column_height;
    logic [9:0]  top_row;
    logic [9:0]  bottom_row;

    slice_t      pending_slices[$];
    int          mismatches;
    int          quiet_cycles;
    logic        calm;

    raycast_column_projection i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .player_pos_x(player_pos_x), .player_pos_y(player_pos_y),
        .dir_x(dir_x), .dir_y(dir_y), .delta_x(delta_x), .delta_y(delta_y),
        .start_cell_x(start_cell_x), .start_cell_y(start_cell_y),
        .hit_cell_x(hit_cell_x), .hit_cell_y(hit_cell_y), .hit_side(hit_side),
        .out_valid(out_valid), .out_stall(out_stall),
        .step_sign_x(step_sign_x), .step_sign_y(step_sign_y),
        .first_dist_x(first_dist_x), .first_dist_y(first_dist_y),
        .wall_dist(wall_dist), .column_height(column_height),
        .top_row(top_row), .bottom_row(bottom_row)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // offset times grid spacing, clamped to [0, DIST_MAX]
    function automatic logic [31:0] side_distance(input longint off, input logic [31:0] len);
        logic [63:0] prod;
        if (off <= 0)
            return 32'd0;
        prod = (64'(off) * 64'(len)) >> 16;
        return (prod > 64'(rcp_pkg::DIST_MAX)) ? rcp_pkg::DIST_MAX : prod[31:0];
    endfunction

    // offset over ray direction, Q16.16
    function automatic logic [31:0] perp_distance(input longint num, input longint ray);
        logic [63:0] quo;
        longint      n;
        longint      d;
        if (ray == 0)
            return rcp_pkg::DIST_MAX;
        if (num == 0 || ((num < 0) != (ray < 0)))
            return 32'd0;
        n = (num < 0) ? -num : num;
        d = (ray < 0) ? -ray : ray;
        quo = (64'(n) << 16) / 64'(d);
        return (quo > 64'(rcp_pkg::DIST_MAX)) ? rcp_pkg::DIST_MAX : quo[31:0];
    endfunction

    function automatic slice_t project_column(input column_t c);
        slice_t      s;
        longint      px;
        longint      py;
        longint      one;
        logic [63:0] h;
        logic [63:0] half;
        one = 65536;
        px = longint'(c.pos_x);
        py = longint'(c.pos_y);
        s.neg_x = c.ray_x < 0;
        s.neg_y = c.ray_y < 0;
        s.side_x = s.neg_x ? side_distance(px - longint'(c.cell_x) * one, c.step_len_x)
                           : side_distance(longint'(c.cell_x) * one + one - px, c.step_len_x);
        s.side_y = s.neg_y ? side_distance(py - longint'(c.cell_y) * one, c.step_len_y)
                           : side_distance(longint'(c.cell_y) * one + one - py, c.step_len_y);
        if (!c.wall_side)
            s.perp = perp_distance(longint'(c.wall_cell_x) * one - px + (s.neg_x ? one : 0),
                                   longint'(c.ray_x));
        else
            s.perp = perp_distance(longint'(c.wall_cell_y) * one - py + (s.neg_y ? one : 0),
                                   longint'(c.ray_y));
        if (s.perp == 0)
            h = 64'(rcp_pkg::HEIGHT_CAP);
        else
        begin
            h = (64'(rcp_pkg::SCREEN_ROWS) << 16) / 64'(s.perp);
            if (h > 64'(rcp_pkg::HEIGHT_CAP))
                h = 64'(rcp_pkg::HEIGHT_CAP);
        end
        half = 64'(rcp_pkg::HALF_ROWS);
        s.height = h[13:0];
        s.top = (h / 2 >= half) ? 10'd0 : 10'(half - h / 2);
        s.bot = (half + h / 2 >= 64'(rcp_pkg::SCREEN_ROWS)) ? 10'(rcp_pkg::SCREEN_ROWS - 1)
                                                             : 10'(half + h / 2);
        return s;
    endfunction

    function automatic column_t random_column();
        column_t c;
        int      mode;
        c.cell_x = 8'($urandom);
        c.cell_y = 8'($urandom);
        mode = $urandom_range(0, 9);
        // mostly a player inside the start cell, sometimes anywhere
        if (mode < 8)
        begin
            c.pos_x = {c.cell_x, 16'($urandom)};
            c.pos_y = {c.cell_y, 16'($urandom)};
        end
        else
        begin
            c.pos_x = 24'($urandom);
            c.pos_y = 24'($urandom);
        end
        c.ray_x = ($urandom_range(0, 15) == 0) ? 18'sd0 : 18'($urandom);
        c.ray_y = ($urandom_range(0, 15) == 0) ? 18'sd0 : 18'($urandom);
        c.step_len_x = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 20'hFFFFF));
        c.step_len_y = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 20'hFFFFF));
        // hit cell a few cells along the ray most of the time
        if (mode < 7)
        begin
            c.wall_cell_x = c.ray_x < 0 ? c.cell_x - 8'($urandom_range(0, 8))
                                        : c.cell_x + 8'($urandom_range(0, 8));
            c.wall_cell_y = c.ray_y < 0 ? c.cell_y - 8'($urandom_range(0, 8))
                                        : c.cell_y + 8'($urandom_range(0, 8));
        end
        else
        begin
            c.wall_cell_x = 8'($urandom);
            c.wall_cell_y = 8'($urandom);
        end
        c.wall_side = 1'($urandom);
        return c;
    endfunction

    function automatic column_t make_col(input logic [23:0] px, input logic [23:0] py,
                                         input logic [17:0] rx, input logic [17:0] ry,
                                         input logic [31:0] lx, input logic [31:0] ly,
                                         input logic [7:0] cx, input logic [7:0] cy,
                                         input logic [7:0] wx, input logic [7:0] wy,
                                         input logic side);
        column_t c;
        c = '{px, py, rx, ry, lx, ly, cx, cy, wx, wy, side};
        return c;
    endfunction

    row_t directed_rows[$];

    task automatic build_directed();
        row_t r;
        // zero direction on hit side: maximum distance, zero height
        r.col = make_col(24'h018000, 24'h018000, 18'sd0, 18'sd65536, 32'h10000, 32'h10000,
                         8'd1, 8'd1, 8'd3, 8'd1, 1'b0);
        r.typed = 1'b1;
        r.want = '{1'b0, 1'b0, 32'h8000, 32'h8000, rcp_pkg::DIST_MAX, 14'd0, 10'd512, 10'd512};
        directed_rows.push_back(r);
        // hit in own cell: zero wall distance, capped height
        r.col = make_col(24'h028000, 24'h028000, 18'sd65536, 18'sd65536, 32'h10000, 32'h10000,
                         8'd2, 8'd2, 8'd2, 8'd2, 1'b0);
        r.want = '{1'b0, 1'b0, 32'h8000, 32'h8000, 32'd0, 14'(rcp_pkg::HEIGHT_CAP),
                   10'd0, 10'd1023};
        directed_rows.push_back(r);
        // player at all-ones, large deltas: saturation; hit cell behind the ray
        r.col = make_col(24'hFFFFFF, 24'hFFFFFF, -18'sd131072, -18'sd131072,
                         32'hFFFFFFFF, 32'hFFFFFFFF, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1);
        r.want = '{1'b1, 1'b1, rcp_pkg::DIST_MAX, rcp_pkg::DIST_MAX, 32'd0,
                   14'(rcp_pkg::HEIGHT_CAP), 10'd0, 10'd1023};
        directed_rows.push_back(r);
        // remaining rows go through the predictor
        r.typed = 1'b0;
        r.col = make_col(24'h0, 24'h0, 18'sd131071, 18'sd1, 32'h0, 32'h0,
                         8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        directed_rows.push_back(r);
        r.col = make_col(24'h0, 24'h0, 18'sd1, 18'sd131071, 32'hFFFFFFFF, 32'hFFFFFFFF,
                         8'd0, 8'd0, 8'd255, 8'd255, 1'b1);
        directed_rows.push_back(r);
        r.col = make_col(24'hFFFFFF, 24'h000000, -18'sd1, 18'sd1, 32'h12345, 32'h1,
                         8'd255, 8'd0, 8'd0, 8'd200, 1'b0);
        directed_rows.push_back(r);
        // hit cell behind the ray
        r.col = make_col(24'h108000, 24'h108000, 18'sd40000, -18'sd40000, 32'h20000, 32'h20000,
                         8'd16, 8'd16, 8'd10, 8'd20, 1'b1);
        directed_rows.push_back(r);
        // player outside start cell
        r.col = make_col(24'h508000, 24'h208000, 18'sd30000, -18'sd30000, 32'h30000, 32'h30000,
                         8'd90, 8'd5, 8'd95, 8'd1, 1'b0);
        directed_rows.push_back(r);
        r.col = make_col(24'h0A4000, 24'h0B4000, -18'sd131072, 18'sd0, 32'h8000, 32'h1000,
                         8'd10, 8'd11, 8'd4, 8'd11, 1'b1);
        directed_rows.push_back(r);
        r.col = make_col(24'h0A4000, 24'h0B4000, 18'sd100, -18'sd100, 32'hFFFF0000, 32'h10,
                         8'd10, 8'd11, 8'd250, 8'd0, 1'b0);
        directed_rows.push_back(r);
    endtask

    // drive one word and wait for acceptance, sometimes after a random gap
    task automatic send_column(input column_t c);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        player_pos_x <= c.pos_x;
        player_pos_y <= c.pos_y;
        dir_x        <= c.ray_x;
        dir_y        <= c.ray_y;
        delta_x      <= c.step_len_x;
        delta_y      <= c.step_len_y;
        start_cell_x <= c.cell_x;
        start_cell_y <= c.cell_y;
        hit_cell_x   <= c.wall_cell_x;
        hit_cell_y   <= c.wall_cell_y;
        hit_side     <= c.wall_side;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // receiver stall bursts
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // compare accepted result words against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_slices.size() == 0)
            begin
                $display("%0t: unexpected result word", $time);
                mismatches++;
            end
            else
            begin
                slice_t w;
                slice_t g;
                w = pending_slices.pop_front();
                g = '{step_sign_x, step_sign_y, first_dist_x, first_dist_y, wall_dist,
                      column_height, top_row, bottom_row};
                if (g.neg_x !== w.neg_x)
                    begin $display("%0t: step_sign_x exp %0d got %0d", $time, w.neg_x, g.neg_x); mismatches++; end
                if (g.neg_y !== w.neg_y)
                    begin $display("%0t: step_sign_y exp %0d got %0d", $time, w.neg_y, g.neg_y); mismatches++; end
                if (g.side_x !== w.side_x)
                    begin $display("%0t: first_dist_x exp %h got %h", $time, w.side_x, g.side_x); mismatches++; end
                if (g.side_y !== w.side_y)
                    begin $display("%0t: first_dist_y exp %h got %h", $time, w.side_y, g.side_y); mismatches++; end
                if (g.perp !== w.perp)
                    begin $display("%0t: wall_dist exp %h got %h", $time, w.perp, g.perp); mismatches++; end
                if (g.height !== w.height)
                    begin $display("%0t: column_height exp %0d got %0d", $time, w.height, g.height); mismatches++; end
                if (g.top !== w.top)
                    begin $display("%0t: top_row exp %0d got %0d", $time, w.top, g.top); mismatches++; end
                if (g.bot !== w.bot)
                    begin $display("%0t: bottom_row exp %0d got %0d", $time, w.bot, g.bot); mismatches++; end
            end
        end
    end

    // count cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("raycast_column_projection regression: fail");
            $finish;
        end
    end

    initial
    begin
        column_t c;
        rst_n = 1'b0;
        in_valid = 1'b0;
        calm = 1'b0;
        {player_pos_x, player_pos_y, dir_x, dir_y, delta_x, delta_y} = '0;
        {start_cell_x, start_cell_y, hit_cell_x, hit_cell_y, hit_side} = '0;
        build_directed();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // walk the directed table
        foreach (directed_rows[i])
        begin
            pending_slices.push_back(directed_rows[i].typed ? directed_rows[i].want
                                                            : project_column(directed_rows[i].col));
            send_column(directed_rows[i].col);
        end
        // random words, last stretch without idling
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS - CALM_WORDS)
                calm = 1'b1;
            c = random_column();
            pending_slices.push_back(project_column(c));
            send_column(c);
        end
        in_valid <= 1'b0;
        while (pending_slices.size() != 0)
            @(posedge clk);
        repeat (rcp_pkg::STAGES + 10) @(posedge clk);
        if (mismatches == 0)
            $display("raycast_column_projection regression: pass");
        else
            $display("raycast_column_projection regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
